>>> rtl/core/cfrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrt_pkg
// Shared types and constants of the control file record tokenizer.
// ----------------------------------------------------------------------------
package cfrt_pkg;

  localparam int KIND_BITS   = 2;
  localparam int CODE_BITS   = 2;
  localparam int FIELD_BITS  = 24;
  localparam int INDEX_BITS  = 16;
  localparam int LINE_BITS   = 24;
  localparam int CLASS_BITS  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  // byte classes
  localparam logic [CLASS_BITS-1:0] CLS_OTHER = 3'd0;
  localparam logic [CLASS_BITS-1:0] CLS_LF    = 3'd1;
  localparam logic [CLASS_BITS-1:0] CLS_CR    = 3'd2;
  localparam logic [CLASS_BITS-1:0] CLS_COLON = 3'd3;
  localparam logic [CLASS_BITS-1:0] CLS_SPACE = 3'd4;
  localparam logic [CLASS_BITS-1:0] CLS_TAB   = 3'd5;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;

  // parse phases
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_KEY     = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_NEWLINE = 3'd3;
  localparam logic [2:0] PH_CONT    = 3'd4;

  // event kinds
  localparam logic [KIND_BITS-1:0] EV_FIELD  = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_RECORD = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_ERROR  = 2'd2;

  // error codes
  localparam logic [CODE_BITS-1:0] ERR_NONE       = 2'd0;
  localparam logic [CODE_BITS-1:0] ERR_KEY_START  = 2'd1;
  localparam logic [CODE_BITS-1:0] ERR_KEY_NEWLINE = 2'd2;
  localparam logic [CODE_BITS-1:0] ERR_KEY_END    = 2'd3;

  typedef struct packed {
    logic [CLASS_BITS-1:0] cls;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [CODE_BITS-1:0]  code;
    logic [FIELD_BITS-1:0] key_start;
    logic [FIELD_BITS-1:0] key_length;
    logic [FIELD_BITS-1:0] value_start;
    logic [FIELD_BITS-1:0] value_length;
    logic [INDEX_BITS-1:0] record_index;
    logic [LINE_BITS-1:0]  line_number;
  } event_t;

  function automatic logic [CLASS_BITS-1:0] classify(input logic [7:0] b);
    logic [CLASS_BITS-1:0] c;
    unique case (b)
      CHR_LF:    c = CLS_LF;
      CHR_CR:    c = CLS_CR;
      CHR_COLON: c = CLS_COLON;
      CHR_SPACE: c = CLS_SPACE;
      CHR_TAB:   c = CLS_TAB;
      default:   c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/cfrt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrt_front
// Input side: takes raw bytes and pushes their class into the queue.
// ----------------------------------------------------------------------------
module cfrt_front (
  input  logic          data_valid,
  output logic          data_ready,
  input  logic [7:0]    data_byte,
  input  logic          is_last,
  output logic          push_valid,
  input  logic          push_ready,
  output cfrt_pkg::item_t push_item
);
  import cfrt_pkg::*;

  assign data_ready     = push_ready;
  assign push_valid     = data_valid;
  assign push_item.cls  = classify(data_byte);
  assign push_item.last = is_last;

endmodule

>>> rtl/core/cfrt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrt_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module cfrt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cfrt_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cfrt_pkg::item_t pop_item
);
  import cfrt_pkg::*;

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t                 entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != COUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/cfrt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrt_back
// Parse state machine: consumes classified items, keeps offsets and counters,
// and loads finished events into the output register.
// ----------------------------------------------------------------------------
module cfrt_back #(
  parameter int POSITION_BITS = 24,
  parameter int RECORD_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cfrt_pkg::item_t  pop_item,
  output logic             event_valid,
  input  logic             event_ready,
  output cfrt_pkg::event_t event_out
);
  import cfrt_pkg::*;

  logic [2:0]               phase, phase_next;
  logic                     halted, halted_next;
  logic                     first_byte, first_byte_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] key_begin, key_begin_next;
  logic [POSITION_BITS-1:0] key_size, key_size_next;
  logic [POSITION_BITS-1:0] value_begin, value_begin_next;
  logic [POSITION_BITS-1:0] value_size, value_size_next;
  logic [RECORD_BITS-1:0]   record_count, record_count_next;
  logic [LINE_BITS-1:0]     line_count, line_count_next;

  logic                     ev_fire;
  logic [KIND_BITS-1:0]     ev_kind;
  logic [CODE_BITS-1:0]     ev_code;
  logic [POSITION_BITS-1:0] ev_ks, ev_kl, ev_vs, ev_vl;
  logic [POSITION_BITS-1:0] pos_plus;
  logic [POSITION_BITS-1:0] vb;
  logic                     count_line;
  logic                     is_ws;
  logic                     take;

  assign pop_ready = !event_valid || event_ready;
  assign take      = pop_valid && pop_ready;
  assign pos_plus  = byte_position + 1'b1;
  assign is_ws     = (pop_item.cls == CLS_SPACE) || (pop_item.cls == CLS_TAB);

  always_comb begin
    phase_next         = phase;
    halted_next        = halted;
    first_byte_next    = first_byte;
    byte_position_next = pos_plus;
    key_begin_next     = key_begin;
    key_size_next      = key_size;
    value_begin_next   = value_begin;
    value_size_next    = value_size;
    record_count_next  = record_count;
    line_count_next    = line_count;
    ev_fire            = 1'b0;
    ev_kind            = EV_FIELD;
    ev_code            = ERR_NONE;
    ev_ks              = '0;
    ev_kl              = '0;
    ev_vs              = '0;
    ev_vl              = '0;
    count_line         = 1'b0;
    vb                 = value_begin;

    if (!halted) begin
      unique case (phase)
        PH_START: begin
          if (pop_item.cls == CLS_LF) begin
            count_line = 1'b1;
          end else if (pop_item.cls == CLS_CR) begin
            phase_next = PH_START;
          end else if (pop_item.cls == CLS_COLON || is_ws) begin
            ev_fire     = 1'b1;
            ev_kind     = EV_ERROR;
            ev_code     = ERR_KEY_START;
            ev_ks       = byte_position;
            halted_next = 1'b1;
          end else begin
            key_begin_next = byte_position;
            phase_next     = PH_KEY;
          end
        end
        PH_KEY: begin
          if (pop_item.cls == CLS_COLON) begin
            key_size_next    = byte_position - key_begin;
            value_begin_next = pos_plus;
            first_byte_next  = 1'b1;
            phase_next       = PH_VALUE;
          end else if (pop_item.cls == CLS_LF) begin
            ev_fire     = 1'b1;
            ev_kind     = EV_ERROR;
            ev_code     = ERR_KEY_NEWLINE;
            ev_ks       = key_begin;
            ev_kl       = byte_position - key_begin;
            halted_next = 1'b1;
          end
        end
        PH_VALUE, PH_CONT: begin
          if (phase == PH_VALUE && first_byte) begin
            first_byte_next = 1'b0;
            if (pop_item.cls == CLS_SPACE) begin
              vb = pos_plus;
            end
          end
          value_begin_next = vb;
          if (pop_item.cls == CLS_LF) begin
            value_size_next = byte_position - vb;
            phase_next      = PH_NEWLINE;
            count_line      = 1'b1;
          end else if (phase == PH_CONT && !is_ws) begin
            phase_next = PH_VALUE;
          end
        end
        PH_NEWLINE: begin
          if (is_ws) begin
            phase_next = PH_CONT;
          end else if (pop_item.cls == CLS_LF || pop_item.cls == CLS_CR) begin
            ev_fire           = 1'b1;
            ev_kind           = EV_RECORD;
            ev_ks             = key_begin;
            ev_kl             = key_size;
            ev_vs             = value_begin;
            ev_vl             = value_size;
            record_count_next = record_count + 1'b1;
            phase_next        = PH_START;
            count_line        = (pop_item.cls == CLS_LF);
          end else begin
            ev_fire        = 1'b1;
            ev_kind        = EV_FIELD;
            ev_ks          = key_begin;
            ev_kl          = key_size;
            ev_vs          = value_begin;
            ev_vl          = value_size;
            key_begin_next = byte_position;
            phase_next     = PH_KEY;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end

    if (count_line && line_count != LINE_MAX) begin
      line_count_next = line_count + 1'b1;
    end

    if (pop_item.last) begin
      if (!halted_next) begin
        if (phase_next == PH_KEY) begin
          ev_fire = 1'b1;
          ev_kind = EV_ERROR;
          ev_code = ERR_KEY_END;
          ev_ks   = key_begin_next;
          ev_kl   = pos_plus - key_begin_next;
          ev_vs   = '0;
          ev_vl   = '0;
        end else if (phase_next == PH_VALUE || phase_next == PH_CONT) begin
          ev_fire = 1'b1;
          ev_kind = EV_RECORD;
          ev_code = ERR_NONE;
          ev_ks   = key_begin_next;
          ev_kl   = key_size_next;
          ev_vs   = value_begin_next;
          ev_vl   = pos_plus - value_begin_next;
        end else if (phase_next == PH_NEWLINE) begin
          ev_fire = 1'b1;
          ev_kind = EV_RECORD;
          ev_code = ERR_NONE;
          ev_ks   = key_begin_next;
          ev_kl   = key_size_next;
          ev_vs   = value_begin_next;
          ev_vl   = value_size_next;
        end
      end
      phase_next         = PH_START;
      halted_next        = 1'b0;
      first_byte_next    = 1'b0;
      byte_position_next = '0;
      key_begin_next     = '0;
      key_size_next      = '0;
      value_begin_next   = '0;
      value_size_next    = '0;
      record_count_next  = '0;
      line_count_next    = LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      halted        <= 1'b0;
      first_byte    <= 1'b0;
      byte_position <= '0;
      key_begin     <= '0;
      key_size      <= '0;
      value_begin   <= '0;
      value_size    <= '0;
      record_count  <= '0;
      line_count    <= LINE_BITS'(1);
    end else if (take) begin
      phase         <= phase_next;
      halted        <= halted_next;
      first_byte    <= first_byte_next;
      byte_position <= byte_position_next;
      key_begin     <= key_begin_next;
      key_size      <= key_size_next;
      value_begin   <= value_begin_next;
      value_size    <= value_size_next;
      record_count  <= record_count_next;
      line_count    <= line_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (pop_ready) begin
      event_valid <= take && ev_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev_fire) begin
      event_out.kind         <= ev_kind;
      event_out.code         <= ev_code;
      event_out.key_start    <= FIELD_BITS'(ev_ks);
      event_out.key_length   <= FIELD_BITS'(ev_kl);
      event_out.value_start  <= FIELD_BITS'(ev_vs);
      event_out.value_length <= FIELD_BITS'(ev_vl);
      event_out.record_index <= INDEX_BITS'(record_count);
      event_out.line_number  <= line_count;
    end
  end

endmodule

>>> rtl/core/control_file_record_tokenizer_core.sv
`timescale 1ns / 1ps
// event path: the causing byte is held in the queue, and the event is loaded into the output register
// throughput: one byte per cycle while the receiver takes events, set by the parse state update
// a two-entry queue between classifier and parser absorbs output stalls
// reset: synchronous, clears queue, parser state and output register
// ----------------------------------------------------------------------------
// control_file_record_tokenizer_core
// Tokenizes a key: value control file byte by byte into field, record and error events.
// ----------------------------------------------------------------------------
module control_file_record_tokenizer_core #(
  parameter int POSITION_BITS = 24,
  parameter int RECORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        event_valid,
  input  logic        event_ready,
  output logic [1:0]  event_kind,
  output logic [1:0]  error_code,
  output logic [23:0] key_start,
  output logic [23:0] key_length,
  output logic [23:0] value_start,
  output logic [23:0] value_length,
  output logic [15:0] record_index,
  output logic [23:0] line_number
);
  import cfrt_pkg::*;

  logic   push_valid;
  logic   push_ready;
  item_t  push_item;
  logic   pop_valid;
  logic   pop_ready;
  item_t  pop_item;
  event_t ev;

  cfrt_front u_front (
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cfrt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cfrt_back #(
    .POSITION_BITS (POSITION_BITS),
    .RECORD_BITS   (RECORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_out   (ev)
  );

  assign event_kind   = ev.kind;
  assign error_code   = ev.code;
  assign key_start    = ev.key_start;
  assign key_length   = ev.key_length;
  assign value_start  = ev.value_start;
  assign value_length = ev.value_length;
  assign record_index = ev.record_index;
  assign line_number  = ev.line_number;

endmodule

>>> rtl/core/cfrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrt_checker
// Port-level checks of the tokenizer's event stream.
// ----------------------------------------------------------------------------
module cfrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        event_valid,
  input logic        event_ready,
  input logic [1:0]  event_kind,
  input logic [1:0]  error_code,
  input logic [23:0] value_start,
  input logic [23:0] value_length,
  input logic [23:0] line_number
);
  import cfrt_pkg::*;

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_kind == EV_FIELD || event_kind == EV_RECORD ||
                     event_kind == EV_ERROR))
    else $error("illegal event kind");

  a_code_match: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> ((event_kind == EV_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match event kind");

  a_error_no_value: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_ERROR) |-> (value_start == '0 && value_length == '0))
    else $error("error item carries a value");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (line_number != '0))
    else $error("line number is zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (event_valid && !event_ready) |=> (event_valid && $stable(event_kind) &&
                                       $stable(line_number)))
    else $error("stalled item changed");

endmodule

bind control_file_record_tokenizer_core cfrt_checker u_cfrt_checker (
  .clk          (clk),
  .rst          (rst),
  .event_valid  (event_valid),
  .event_ready  (event_ready),
  .event_kind   (event_kind),
  .error_code   (error_code),
  .value_start  (value_start),
  .value_length (value_length),
  .line_number  (line_number)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the control file record tokenizer core. Short byte
// files, first hand-picked and then random, are pushed through the byte
// channel with bursts and gaps. An in-bench tokenizer predicts the field,
// record and error events, and each event taken from the core, under a
// stalling receiver, is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import cfrt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int TARGET_BYTES = 620;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        event_valid;
  logic        event_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [1:0]  error_code;
  logic [23:0] key_start;
  logic [23:0] key_length;
  logic [23:0] value_start;
  logic [23:0] value_length;
  logic [15:0] record_index;
  logic [23:0] line_number;

  file_byte_t  pending_bytes[$];
  logic [7:0]  file_buf[$];
  event_t      expected_events[$];
  file_byte_t  next_byte;

  logic        byte_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          accepted_bytes = 0;
  int          idle_cycles = 0;
  int          mismatch_count = 0;

  // tokenizer state
  logic [2:0]  phase;
  logic        halted;
  logic        first_value_byte;
  logic [23:0] byte_pos;
  logic [23:0] key_beg;
  logic [23:0] key_sz;
  logic [23:0] val_beg;
  logic [23:0] val_sz;
  logic [15:0] record_cnt;
  logic [23:0] line_cnt;

  always #10 clk = ~clk;

  control_file_record_tokenizer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .error_code   (error_code),
    .key_start    (key_start),
    .key_length   (key_length),
    .value_start  (value_start),
    .value_length (value_length),
    .record_index (record_index),
    .line_number  (line_number)
  );

  task automatic clear_tokenizer();
    phase = PH_START;
    halted = 1'b0;
    first_value_byte = 1'b0;
    byte_pos = '0;
    key_beg = '0;
    key_sz = '0;
    val_beg = '0;
    val_sz = '0;
    record_cnt = '0;
    line_cnt = 24'd1;
  endtask

  function automatic event_t make_event(input logic [1:0] kind, input logic [1:0] code,
                                        input logic [23:0] ks, input logic [23:0] kl,
                                        input logic [23:0] vs, input logic [23:0] vl,
                                        input logic [23:0] line);
    event_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.key_start = ks;
    ev.key_length = kl;
    ev.value_start = vs;
    ev.value_length = vl;
    ev.record_index = record_cnt;
    ev.line_number = line;
    return ev;
  endfunction

  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    logic [23:0] pos;
    logic [23:0] nxt;
    logic [23:0] line;
    logic        count_line;
    logic        have;
    event_t      ev;
    pos = byte_pos;
    nxt = pos + 24'd1;
    line = line_cnt;
    count_line = 1'b0;
    have = 1'b0;
    ev = '0;
    if (!halted) begin
      case (phase)
        PH_START: begin
          if (b == CHR_LF) begin
            count_line = 1'b1;
          end else if (b == CHR_CR) begin
          end else if (b == CHR_COLON || b == CHR_SPACE || b == CHR_TAB) begin
            ev = make_event(EV_ERROR, ERR_KEY_START, pos, '0, '0, '0, line);
            have = 1'b1;
            halted = 1'b1;
          end else begin
            key_beg = pos;
            phase = PH_KEY;
          end
        end
        PH_KEY: begin
          if (b == CHR_COLON) begin
            key_sz = pos - key_beg;
            val_beg = nxt;
            first_value_byte = 1'b1;
            phase = PH_VALUE;
          end else if (b == CHR_LF) begin
            ev = make_event(EV_ERROR, ERR_KEY_NEWLINE, key_beg, pos - key_beg, '0, '0, line);
            have = 1'b1;
            halted = 1'b1;
          end
        end
        PH_VALUE, PH_CONT: begin
          if (phase == PH_VALUE && first_value_byte) begin
            first_value_byte = 1'b0;
            if (b == CHR_SPACE) val_beg = nxt;
          end
          if (b == CHR_LF) begin
            val_sz = pos - val_beg;
            phase = PH_NEWLINE;
            count_line = 1'b1;
          end else if (phase == PH_CONT && b != CHR_SPACE && b != CHR_TAB) begin
            phase = PH_VALUE;
          end
        end
        default: begin
          if (b == CHR_SPACE || b == CHR_TAB) begin
            phase = PH_CONT;
          end else if (b == CHR_LF || b == CHR_CR) begin
            ev = make_event(EV_RECORD, ERR_NONE, key_beg, key_sz, val_beg, val_sz, line);
            have = 1'b1;
            record_cnt = record_cnt + 16'd1;
            phase = PH_START;
            count_line = (b == CHR_LF);
          end else begin
            ev = make_event(EV_FIELD, ERR_NONE, key_beg, key_sz, val_beg, val_sz, line);
            have = 1'b1;
            key_beg = pos;
            phase = PH_KEY;
          end
        end
      endcase
    end
    if (count_line && line_cnt != LINE_MAX) line_cnt = line_cnt + 24'd1;
    byte_pos = nxt;
    if (last) begin
      if (!halted) begin
        if (phase == PH_KEY) begin
          ev = make_event(EV_ERROR, ERR_KEY_END, key_beg, nxt - key_beg, '0, '0, line);
          have = 1'b1;
        end else if (phase == PH_VALUE || phase == PH_CONT) begin
          ev = make_event(EV_RECORD, ERR_NONE, key_beg, key_sz, val_beg, nxt - val_beg, line);
          have = 1'b1;
        end else if (phase == PH_NEWLINE) begin
          ev = make_event(EV_RECORD, ERR_NONE, key_beg, key_sz, val_beg, val_sz, line);
          have = 1'b1;
        end
      end
      clear_tokenizer();
    end
    if (have) expected_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input logic [23:0] exp, input logic [23:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  // stimulus building
  task automatic push_byte(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endtask

  task automatic flush_file();
    file_byte_t fb;
    while (file_buf.size() != 0) begin
      fb.b = file_buf.pop_front();
      fb.last = (file_buf.size() == 0);
      pending_bytes.push_back(fb);
    end
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CHR_LF || b == CHR_CR || b == CHR_COLON || b == CHR_SPACE || b == CHR_TAB);
    return b;
  endfunction

  function automatic logic [7:0] key_tail_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : plain_byte();
    end while (b == CHR_LF || b == CHR_COLON);
    return b;
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CHR_LF);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CHR_LF;
      1: b = CHR_CR;
      2: b = CHR_COLON;
      3: b = CHR_SPACE;
      4: b = CHR_TAB;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic add_field();
    int klen;
    int vlen;
    klen = $urandom_range(0, 3);
    push_byte(plain_byte());
    repeat (klen) push_byte(key_tail_byte());
    push_byte(CHR_COLON);
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        push_byte(CHR_SPACE);
        push_byte(CHR_SPACE);
      end
      default: push_byte(CHR_SPACE);
    endcase
    vlen = $urandom_range(0, 5);
    repeat (vlen) push_byte(value_byte());
    push_byte(CHR_LF);
    while ($urandom_range(0, 3) == 0) begin
      push_byte(($urandom_range(0, 1) == 0) ? CHR_SPACE : CHR_TAB);
      vlen = $urandom_range(0, 4);
      repeat (vlen) push_byte(value_byte());
      push_byte(CHR_LF);
    end
  endtask

  task automatic build_random_file();
    int style;
    int n_rec;
    int n_fld;
    int drop;
    style = $urandom_range(0, 9);
    if (style < 7) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) push_byte(CHR_CR);
        push_byte(CHR_LF);
      end
      n_rec = $urandom_range(1, 3);
      for (int r = 0; r < n_rec; r++) begin
        n_fld = $urandom_range(1, 3);
        repeat (n_fld) add_field();
        if (r < n_rec - 1 || $urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            push_byte(CHR_CR);
            push_byte(CHR_LF);
          end else begin
            push_byte(CHR_LF);
          end
        end
      end
      // cut short so the file ends in any phase
      if (style == 6 && file_buf.size() > 1) begin
        drop = $urandom_range(1, file_buf.size() - 1);
        repeat (drop) void'(file_buf.pop_back());
      end
    end else if (style < 9) begin
      if ($urandom_range(0, 1) == 0) begin
        add_field();
        push_byte(CHR_LF);
      end
      case ($urandom_range(0, 3))
        0: push_byte(CHR_COLON);
        1: push_byte(CHR_SPACE);
        2: push_byte(CHR_TAB);
        default: begin
          push_byte(plain_byte());
          repeat ($urandom_range(0, 2)) push_byte(key_tail_byte());
          push_byte(CHR_LF);
        end
      endcase
      repeat ($urandom_range(0, 4)) push_byte(noise_byte());
    end else begin
      repeat ($urandom_range(1, 12)) push_byte(noise_byte());
    end
    flush_file();
  endtask

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (data_valid && !byte_taken) begin
    end else if (gap_left != 0 || pending_bytes.size() == 0) begin
      data_valid <= 1'b0;
      if (gap_left != 0) gap_left <= gap_left - 1;
    end else begin
      next_byte = pending_bytes.pop_front();
      data_byte <= next_byte.b;
      is_last <= next_byte.last;
      data_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // event receiver
  always @(negedge clk) begin
    if (rst) begin
      event_ready <= 1'b0;
    end else if (hold_left != 0) begin
      event_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_bytes >= 250) begin
      event_ready <= 1'b0;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(5, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: event_ready <= 1'b1;
        1: event_ready <= 1'($urandom_range(0, 1));
        default: event_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    event_t exp;
    byte_taken <= !rst && data_valid && data_ready;
    if (!rst && data_valid && data_ready) begin
      tokenize_byte(data_byte, is_last);
      accepted_bytes <= accepted_bytes + 1;
    end
    if (!rst && event_valid && event_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d code %0d",
                 $time, event_kind, error_code);
        mismatch_count++;
      end else begin
        exp = expected_events.pop_front();
        check_field("event_kind", 24'(exp.kind), 24'(event_kind));
        check_field("error_code", 24'(exp.code), 24'(error_code));
        check_field("key_start", exp.key_start, key_start);
        check_field("key_length", exp.key_length, key_length);
        check_field("value_start", exp.value_start, value_start);
        check_field("value_length", exp.value_length, value_length);
        check_field("record_index", 24'(exp.record_index), 24'(record_index));
        check_field("line_number", exp.line_number, line_number);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((data_valid && data_ready) || (event_valid && event_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    clear_tokenizer();

    // colon, space and tab at record start
    push_byte(CHR_COLON);
    flush_file();
    push_byte(CHR_CR);
    push_byte(CHR_LF);
    push_byte(CHR_SPACE);
    flush_file();
    push_byte(CHR_TAB);
    flush_file();
    // newline inside a key, file ending inside a key
    add_text("a");
    push_byte(CHR_LF);
    flush_file();
    push_byte(8'hFF);
    flush_file();
    // whitespace-only continuation, record ended by cr
    add_text("k");
    push_byte(CHR_COLON);
    push_byte(CHR_SPACE);
    add_text("v");
    push_byte(CHR_LF);
    push_byte(CHR_SPACE);
    push_byte(CHR_LF);
    add_text("m");
    push_byte(CHR_COLON);
    push_byte(8'h00);
    push_byte(CHR_LF);
    push_byte(CHR_CR);
    flush_file();
    // last byte closes a field and opens a key
    add_text("k");
    push_byte(CHR_COLON);
    add_text("v");
    push_byte(CHR_LF);
    add_text("x");
    flush_file();
    // last byte right after the value newline
    add_text("k");
    push_byte(CHR_COLON);
    push_byte(CHR_LF);
    flush_file();

    while (pending_bytes.size() < TARGET_BYTES) build_random_file();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || data_valid) @(negedge clk);
    while (expected_events.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
